// ----- hw/rtl/sm3_hash_engine_defines.svh -----
// ----------------------------------------------------------------------------
// SM3 hash engine assertion macros
// These are shared checking macros. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a property holds on every clock edge outside reset.
`define SM3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sm3 hash engine: assertion failed");

// Checks that a condition implies a result in the same cycle.
`define SM3_ASSERT_IMPL(lbl, ante, cons) \
  `SM3_ASSERT(lbl, (ante) |-> (cons))

`else

`define SM3_ASSERT(lbl, prop)
`define SM3_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Types, constants and round functions that the engine's files share.
// ----------------------------------------------------------------------------
package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0]  wptr_t;
  typedef logic [5:0]  round_t;
  typedef logic [2:0]  didx_t;
  typedef logic [2:0]  bcount_t;
  typedef logic [63:0] blen_t;

  localparam int unsigned NUM_HASH_WORDS = 8;
  localparam int unsigned BLK_WORDS      = 16;

  localparam word_t IV [NUM_HASH_WORDS] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam word_t   T0         = 32'h79CC4519;
  localparam word_t   T1         = 32'h7A879D8A;
  localparam word_t   PAD_WORD   = 32'h80000000;
  localparam word_t   ZERO_WORD  = 32'h00000000;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam wptr_t   LEN_HI_POS    = 4'd14;
  localparam wptr_t   LEN_LO_POS    = 4'd15;
  localparam wptr_t   BLK_LAST_POS  = 4'd15;
  localparam round_t  LAST_ROUND    = 6'd63;
  localparam round_t  T_SWITCH_ROUND = 6'd15;
  localparam round_t  XOR_ROUNDS    = 6'd16;
  localparam didx_t   LAST_DIDX     = 3'd7;
  localparam bcount_t FULL_COUNT    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic   init;
    logic   load;
    logic   step;
    round_t round;
  } core_ctrl_t;

  // Rotate left by a constant amount between 1 and 31.
  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t p0(input word_t x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic word_t p1(input word_t x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

endpackage

// ----- hw/rtl/sm3_if.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine channels
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sm3_in_if import sm3_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   data_word;
  bcount_t byte_count;
  logic    last_item;

  modport source (output valid, output data_word, output byte_count, output last_item,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last_item,
                  output ready);
endinterface

interface sm3_out_if import sm3_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t digest_word;
  didx_t word_index;
  logic  last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ----- hw/rtl/sm3_msg_sched.sv -----
// ----------------------------------------------------------------------------
// SM3 message schedule
// Holds the 16-word block and, while rounds run, slides it as a window
// over the expanded message, producing one new word per round.
// ----------------------------------------------------------------------------
module sm3_msg_sched import sm3_pkg::*; (
  input  logic  clk,
  input  logic  wr_en,
  input  wptr_t wr_idx,
  input  word_t wr_data,
  input  logic  shift,
  output word_t w_cur,
  output word_t w_prime
);

  word_t win_r [BLK_WORDS];
  word_t expand;

  // Window slot i holds W[j+i] during round j.
  assign expand = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 15))
                  ^ rotl(win_r[3], 7) ^ win_r[10];

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[BLK_WORDS - 1] <= expand;
    end else if (wr_en) begin
      win_r[wr_idx] <= wr_data;
    end
  end

  assign w_cur   = win_r[0];
  assign w_prime = win_r[0] ^ win_r[4];

endmodule

// ----- hw/rtl/sm3_core.sv -----
// ----------------------------------------------------------------------------
// SM3 compression core
// Chaining state and one shared round unit that runs a round per cycle.
// ----------------------------------------------------------------------------
module sm3_core import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  core_ctrl_t ctrl,
  input  word_t      w_cur,
  input  word_t      w_prime,
  input  didx_t      rd_idx,
  output word_t      rd_word
);

  word_t hash_r [NUM_HASH_WORDS];
  word_t work_r [NUM_HASH_WORDS];
  word_t work_nxt [NUM_HASH_WORDS];
  word_t tj_r;
  word_t tj_nxt;
  word_t a12;
  word_t ss1;
  word_t ss2;
  word_t ff;
  word_t gg;
  word_t tt1;
  word_t tt2;

  always_comb begin
    a12 = rotl(work_r[0], 12);
    ss1 = rotl(a12 + work_r[4] + tj_r, 7);
    ss2 = ss1 ^ a12;
    if (ctrl.round < XOR_ROUNDS) begin
      ff = work_r[0] ^ work_r[1] ^ work_r[2];
      gg = work_r[4] ^ work_r[5] ^ work_r[6];
    end else begin
      ff = (work_r[0] & work_r[1]) | (work_r[0] & work_r[2]) | (work_r[1] & work_r[2]);
      gg = (work_r[4] & work_r[5]) | (~work_r[4] & work_r[6]);
    end
    tt1 = ff + work_r[3] + ss2 + w_prime;
    tt2 = gg + work_r[7] + ss1 + w_cur;

    work_nxt[0] = tt1;
    work_nxt[1] = work_r[0];
    work_nxt[2] = rotl(work_r[1], 9);
    work_nxt[3] = work_r[2];
    work_nxt[4] = p0(tt2);
    work_nxt[5] = work_r[4];
    work_nxt[6] = rotl(work_r[5], 19);
    work_nxt[7] = work_r[6];

    // The round constant is kept pre-rotated: one more bit per round, and
    // the second constant starts at a rotation of sixteen.
    if (ctrl.round == T_SWITCH_ROUND) begin
      tj_nxt = rotl(T1, 16);
    end else begin
      tj_nxt = rotl(tj_r, 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_HASH_WORDS; i++) begin
        hash_r[i] <= IV[i];
      end
    end else if (ctrl.init) begin
      for (int i = 0; i < NUM_HASH_WORDS; i++) begin
        hash_r[i] <= IV[i];
      end
    end else if (ctrl.step && (ctrl.round == LAST_ROUND)) begin
      for (int i = 0; i < NUM_HASH_WORDS; i++) begin
        hash_r[i] <= hash_r[i] ^ work_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work_r <= hash_r;
      tj_r   <= T0;
    end else if (ctrl.step) begin
      work_r <= work_nxt;
      tj_r   <= tj_nxt;
    end
  end

  assign rd_word = hash_r[rd_idx];

endmodule

// ----- hw/rtl/sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine
// Packs message words into 64-byte blocks, pads the message on its last
// word and compresses each block with a shared one-round-per-cycle unit.
//
//   Channel  Dir  Payload                               Per word
//   in_ch    in   data_word, byte_count, last_item      up to 4 message bytes
//   out_ch   out  digest_word, word_index, last_word    one digest word
//
// A word that completes a block is followed by the rounds of its compression
// in the round unit. A last word is followed by the padding words, one or
// two compressions and then the eight digest words. No input is taken
// while a block is being padded or compressed.
// Reset is synchronous; no clearing pass is needed. A stalled digest word
// holds until it is taken; no input is taken while a digest is pending.
// ----------------------------------------------------------------------------
`include "sm3_hash_engine_defines.svh"

module sm3_hash_engine import sm3_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  state_t     state_r, state_nxt;
  wptr_t      wptr_r, wptr_nxt;
  round_t     round_r, round_nxt;
  didx_t      didx_r, didx_nxt;
  blen_t      bit_len_r, bit_len_nxt;
  logic       pad_r, pad_nxt;
  logic       pend80_r, pend80_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       len_done_r, len_done_nxt;

  logic       in_accept;
  logic       out_accept;
  bcount_t    cnt;
  word_t      tail_word;
  logic       wr_en;
  word_t      wr_data;
  core_ctrl_t ctrl;
  word_t      w_cur;
  word_t      w_prime;
  word_t      rd_word;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_accept   = out_ch.valid && out_ch.ready;

  // Only the last word may carry fewer than four bytes.
  always_comb begin
    if (!in_ch.last_item || (in_ch.byte_count > FULL_COUNT)) begin
      cnt = FULL_COUNT;
    end else begin
      cnt = in_ch.byte_count;
    end
  end

  // The last word carries its bytes followed by the 0x80 marker, unless it
  // is full and the marker goes into the next word.
  always_comb begin
    case (cnt)
      3'd0:    tail_word = PAD_WORD;
      3'd1:    tail_word = {in_ch.data_word[31:24], PAD_BYTE, 16'h0000};
      3'd2:    tail_word = {in_ch.data_word[31:16], PAD_BYTE, 8'h00};
      3'd3:    tail_word = {in_ch.data_word[31:8], PAD_BYTE};
      default: tail_word = in_ch.data_word;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    wptr_nxt     = wptr_r;
    round_nxt    = round_r;
    didx_nxt     = didx_r;
    bit_len_nxt  = bit_len_r;
    pad_nxt      = pad_r;
    pend80_nxt   = pend80_r;
    len_ok_nxt   = len_ok_r;
    len_done_nxt = len_done_r;
    wr_en        = 1'b0;
    wr_data      = tail_word;
    ctrl         = '0;
    ctrl.round   = round_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          wr_en       = 1'b1;
          wptr_nxt    = wptr_r + 4'd1;
          bit_len_nxt = bit_len_r + {58'd0, cnt, 3'b000};
          if (in_ch.last_item) begin
            pad_nxt      = 1'b1;
            pend80_nxt   = (cnt == FULL_COUNT);
            len_ok_nxt   = (cnt != FULL_COUNT) && (wptr_r < LEN_HI_POS);
            len_done_nxt = 1'b0;
          end
          if (wptr_r == BLK_LAST_POS) begin
            ctrl.load = 1'b1;
            round_nxt = '0;
            state_nxt = S_COMP;
          end else if (in_ch.last_item) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        wr_en    = 1'b1;
        wptr_nxt = wptr_r + 4'd1;
        if (pend80_r) begin
          wr_data    = PAD_WORD;
          pend80_nxt = 1'b0;
          len_ok_nxt = (wptr_r < LEN_HI_POS);
        end else if (len_ok_r && (wptr_r == LEN_HI_POS)) begin
          wr_data = bit_len_r[63:32];
        end else if (len_ok_r && (wptr_r == LEN_LO_POS)) begin
          wr_data      = bit_len_r[31:0];
          len_done_nxt = 1'b1;
        end else begin
          wr_data = ZERO_WORD;
        end
        if (wptr_r == BLK_LAST_POS) begin
          ctrl.load = 1'b1;
          round_nxt = '0;
          state_nxt = S_COMP;
        end
      end

      S_COMP: begin
        ctrl.step = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          if (!pad_r) begin
            state_nxt = S_IDLE;
          end else if (len_done_r) begin
            didx_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            // The length did not fit after the marker: a fresh block follows.
            len_ok_nxt = 1'b1;
            state_nxt  = S_PAD;
          end
        end
      end

      S_OUT: begin
        if (out_accept) begin
          didx_nxt = didx_r + 3'd1;
          if (didx_r == LAST_DIDX) begin
            ctrl.init    = 1'b1;
            bit_len_nxt  = '0;
            pad_nxt      = 1'b0;
            len_done_nxt = 1'b0;
            len_ok_nxt   = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wptr_r     <= '0;
      round_r    <= '0;
      didx_r     <= '0;
      bit_len_r  <= '0;
      pad_r      <= 1'b0;
      pend80_r   <= 1'b0;
      len_ok_r   <= 1'b0;
      len_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wptr_r     <= wptr_nxt;
      round_r    <= round_nxt;
      didx_r     <= didx_nxt;
      bit_len_r  <= bit_len_nxt;
      pad_r      <= pad_nxt;
      pend80_r   <= pend80_nxt;
      len_ok_r   <= len_ok_nxt;
      len_done_r <= len_done_nxt;
    end
  end

  sm3_msg_sched u_sched (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wptr_r),
    .wr_data (wr_data),
    .shift   (ctrl.step),
    .w_cur   (w_cur),
    .w_prime (w_prime)
  );

  sm3_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .w_cur   (w_cur),
    .w_prime (w_prime),
    .rd_idx  (didx_r),
    .rd_word (rd_word)
  );

  assign out_ch.digest_word = rd_word;
  assign out_ch.word_index  = didx_r;
  assign out_ch.last_word   = (didx_r == LAST_DIDX);

  `SM3_ASSERT(a_one_side_open, !(in_ch.ready && out_ch.valid))
  `SM3_ASSERT(a_rounds_end, (state_r == S_COMP && round_r == LAST_ROUND) |=> state_r != S_COMP)
  `SM3_ASSERT(a_digest_clears, (out_accept && out_ch.last_word) |=> (bit_len_r == '0 && !pad_r))
  `SM3_ASSERT_IMPL(a_out_block_aligned, out_ch.valid, wptr_r == '0 && len_done_r)

endmodule

// ----- dv/tb_sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams whole messages into the engine with random idle bursts on both
// channels. A local bit-exact SM3 predictor models the padding and
// compression, and every digest word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine;
  import sm3_pkg::*;

  localparam int unsigned BLOCK_BYTES   = 64;
  localparam int unsigned LEN_FIELD_POS = 56;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned TAIL_ITEMS    = 40;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    word_t   data;
    bcount_t count;
    logic    last;
    logic    wait_drain;
  } msg_item_t;

  typedef struct {
    word_t digest;
    didx_t index;
    logic  last;
  } digest_word_t;

  logic clk;
  logic rst_n;

  sm3_in_if  msg_ch ();
  sm3_out_if dig_ch ();

  sm3_hash_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (msg_ch),
    .out_ch (dig_ch)
  );

  msg_item_t    pending_q [$];
  digest_word_t digest_exp_q [$];
  msg_item_t    next_item;

  word_t        chain_val [NUM_HASH_WORDS];
  word_t        msg_block [BLK_WORDS];
  int unsigned  blk_pos;
  logic [63:0]  msg_bits;

  logic         word_taken;
  int unsigned  send_gap;
  int unsigned  recv_gap;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  cycle_count;
  int unsigned  mismatch_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // SM3 predictor
  // --------------------------------------------------------------------------
  function automatic word_t rot_left(word_t x, int unsigned n);
    int unsigned k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic word_t perm_p0(word_t x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic word_t perm_p1(word_t x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  task automatic compress_msg_block();
    word_t w [68];
    word_t a, b, c, d, e, f, g, h;
    word_t ss1, ss2, tt1, tt2, ff, gg, tj;
    for (int j = 0; j < 16; j++) w[j] = msg_block[j];
    for (int j = 16; j < 68; j++)
      w[j] = perm_p1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15)) ^ rot_left(w[j-13], 7) ^ w[j-6];
    a = chain_val[0]; b = chain_val[1]; c = chain_val[2]; d = chain_val[3];
    e = chain_val[4]; f = chain_val[5]; g = chain_val[6]; h = chain_val[7];
    for (int j = 0; j < 64; j++) begin
      if (j < 16) begin
        tj = T0;
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        tj = T1;
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      ss1 = rot_left(rot_left(a, 12) + e + rot_left(tj, j), 7);
      ss2 = ss1 ^ rot_left(a, 12);
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rot_left(b, 9); b = a; a = tt1;
      h = g; g = rot_left(f, 19); f = e; e = perm_p0(tt2);
    end
    chain_val[0] ^= a; chain_val[1] ^= b; chain_val[2] ^= c; chain_val[3] ^= d;
    chain_val[4] ^= e; chain_val[5] ^= f; chain_val[6] ^= g; chain_val[7] ^= h;
  endtask

  task automatic push_msg_byte(logic [7:0] value);
    int unsigned idx;
    int unsigned sh;
    idx = blk_pos / 4;
    sh  = (3 - (blk_pos % 4)) * 8;
    msg_block[idx] = (msg_block[idx] & ~(32'hFF << sh)) | (word_t'(value) << sh);
    blk_pos++;
    if (blk_pos == BLOCK_BYTES) begin
      compress_msg_block();
      blk_pos = 0;
    end
  endtask

  // Absorbs one accepted word; a last word pads, finishes the message and
  // queues the eight digest words.
  task automatic absorb_msg_word(word_t data, bcount_t count, logic last);
    int unsigned nbytes;
    logic [63:0] len_snapshot;
    digest_word_t dw;
    nbytes = !last ? FULL_COUNT : (count > FULL_COUNT ? FULL_COUNT : count);
    for (int i = 0; i < nbytes; i++) begin
      push_msg_byte(data[31 - 8*i -: 8]);
      msg_bits += 64'd8;
    end
    if (last) begin
      len_snapshot = msg_bits;
      push_msg_byte(PAD_BYTE);
      while (blk_pos != LEN_FIELD_POS) push_msg_byte(8'h00);
      for (int i = 0; i < 8; i++) push_msg_byte(len_snapshot[63 - 8*i -: 8]);
      for (int i = 0; i < NUM_HASH_WORDS; i++) begin
        dw.digest = chain_val[i];
        dw.index  = didx_t'(i);
        dw.last   = (didx_t'(i) == LAST_DIDX);
        digest_exp_q.push_back(dw);
      end
      chain_val = IV;
      blk_pos   = 0;
      msg_bits  = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_word(word_t data, bcount_t count, logic last, logic wait_drain);
    msg_item_t it;
    it.data       = data;
    it.count      = count;
    it.last       = last;
    it.wait_drain = wait_drain;
    pending_q.push_back(it);
  endtask

  // Non-last words carry a random count, which the engine must ignore.
  task automatic queue_message(int unsigned body_words, logic wait_drain);
    for (int i = 0; i < body_words; i++)
      queue_word($urandom, bcount_t'($urandom_range(0, 7)), 1'b0, wait_drain && i == 0);
    queue_word($urandom, bcount_t'($urandom_range(0, 7)), 1'b1,
               wait_drain && body_words == 0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one word at a time from pending_q, valid held until taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      msg_ch.valid <= 1'b0;
    end else if (msg_ch.valid && !word_taken) begin
      // Word still waiting for ready; keep it on the channel.
    end else if (send_gap > 0) begin
      send_gap--;
      msg_ch.valid <= 1'b0;
    end else if (pending_q.size() == 0 ||
                 (pending_q[0].wait_drain && digest_exp_q.size() != 0)) begin
      msg_ch.valid <= 1'b0;
    end else if (pending_q.size() > TAIL_ITEMS && $urandom_range(1, 100) <= send_idle_pct) begin
      send_gap = $urandom_range(0, 11);
      msg_ch.valid <= 1'b0;
    end else begin
      next_item = pending_q.pop_front();
      msg_ch.data_word  <= next_item.data;
      msg_ch.byte_count <= next_item.count;
      msg_ch.last_item  <= next_item.last;
      msg_ch.valid      <= 1'b1;
    end
  end

  // Digest side back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      dig_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      dig_ch.ready <= 1'b0;
    end else if (pending_q.size() > TAIL_ITEMS && $urandom_range(1, 100) <= recv_idle_pct) begin
      recv_gap = $urandom_range(0, 11);
      dig_ch.ready <= 1'b0;
    end else begin
      dig_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and checker
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, digest_word_t exp_w, digest_word_t got_w);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0d] %s: expected %h idx %0d last %b, got %h idx %0d last %b",
               cycle_count, what, exp_w.digest, exp_w.index, exp_w.last,
               got_w.digest, got_w.index, got_w.last);
  endtask

  always @(posedge clk) begin
    digest_word_t got_w;
    digest_word_t exp_w;
    word_taken = rst_n && msg_ch.valid && msg_ch.ready;
    if (rst_n && dig_ch.valid && dig_ch.ready) begin
      got_w.digest = dig_ch.digest_word;
      got_w.index  = dig_ch.word_index;
      got_w.last   = dig_ch.last_word;
      if (digest_exp_q.size() == 0) begin
        exp_w = '{digest: '0, index: '0, last: 1'b0};
        note_mismatch("unexpected digest word", exp_w, got_w);
      end else begin
        exp_w = digest_exp_q.pop_front();
        if (got_w.digest !== exp_w.digest || got_w.index !== exp_w.index ||
            got_w.last !== exp_w.last)
          note_mismatch("digest word mismatch", exp_w, got_w);
      end
    end
    if (word_taken)
      absorb_msg_word(msg_ch.data_word, msg_ch.byte_count, msg_ch.last_item);
  end

  // Cycle counter, timeout, and changing idle density so that some stretches
  // run with no gaps at all.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: send_idle_pct = 0;
        1: send_idle_pct = 5;
        2: send_idle_pct = 20;
        default: send_idle_pct = 50;
      endcase
      case ($urandom_range(0, 3))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 5;
        2: recv_idle_pct = 20;
        default: recv_idle_pct = 50;
      endcase
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_items;
    int unsigned body_words;

    rst_n             = 1'b0;
    msg_ch.valid      = 1'b0;
    msg_ch.data_word  = '0;
    msg_ch.byte_count = '0;
    msg_ch.last_item  = 1'b0;
    dig_ch.ready      = 1'b0;
    word_taken        = 1'b0;
    send_gap          = 0;
    recv_gap          = 0;
    send_idle_pct     = 20;
    recv_idle_pct     = 20;
    cycle_count       = 0;
    mismatch_count    = 0;
    chain_val         = IV;
    for (int i = 0; i < BLK_WORDS; i++) msg_block[i] = ZERO_WORD;
    blk_pos           = 0;
    msg_bits          = '0;

    // Directed: empty message, "abc", saturated counts, short counts after
    // ignored counts, all-ones and all-zero data, and a 55-byte message whose
    // padding just fits in one block.
    queue_word(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0);
    queue_word(32'h6162_6300, 3'd3, 1'b1, 1'b0);
    queue_word(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0);
    queue_word(32'hFFFF_FFFF, 3'd3, 1'b0, 1'b0);
    queue_word(32'h1234_5678, 3'd1, 1'b1, 1'b0);
    queue_word(32'h0000_0000, 3'd7, 1'b0, 1'b0);
    queue_word(32'hA5A5_A5A5, 3'd2, 1'b1, 1'b0);
    queue_word(32'h0000_0000, 3'd4, 1'b1, 1'b0);
    for (int i = 0; i < 13; i++)
      queue_word($urandom, bcount_t'($urandom_range(0, 7)), 1'b0, 1'b0);
    queue_word($urandom, 3'd3, 1'b1, 1'b0);

    // Random messages: half short, a fifth sized near the padding boundary,
    // the rest long enough to span several blocks.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: body_words = $urandom_range(0, 8);
        5, 6: begin
          case ($urandom_range(0, 5))
            0: body_words = 13;
            1: body_words = 14;
            2: body_words = 15;
            3: body_words = 29;
            4: body_words = 30;
            default: body_words = 31;
          endcase
        end
        7, 8: body_words = $urandom_range(16, 40);
        default: body_words = $urandom_range(41, 80);
      endcase
      // The first random message waits for the digest backlog to drain.
      queue_message(body_words, random_items == 0 || $urandom_range(0, 7) == 0);
      random_items += body_words + 1;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || msg_ch.valid) @(posedge clk);
    while (digest_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && digest_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
